[design/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define CRD_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define CRD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/crd_pkg.sv]
// ---------------------------------------------------------------------------
// crd_pkg
// Types, register codes and reset values of the click region detector.
// ---------------------------------------------------------------------------
package crd_pkg;

    localparam int INDEX_BITS = 32;

    typedef logic [INDEX_BITS-1:0] idx_t;

    localparam int CFG_INDEX_BITS = 4;
    localparam int CFG_DATA_BITS  = 16;

    typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;

    localparam cfg_index_t CFG_START_THRESHOLD    = 4'd0;
    localparam cfg_index_t CFG_CONTINUE_THRESHOLD = 4'd1;
    localparam cfg_index_t CFG_MAX_LENGTH         = 4'd2;
    localparam cfg_index_t CFG_MIN_LENGTH         = 4'd3;
    localparam cfg_index_t CFG_COOLDOWN_LENGTH    = 4'd4;
    localparam cfg_index_t CFG_PRE_MARGIN         = 4'd5;
    localparam cfg_index_t CFG_POST_MARGIN        = 4'd6;
    localparam cfg_index_t CFG_LOOKAHEAD          = 4'd7;

    typedef struct packed {
        logic [15:0] start_threshold;
        logic [15:0] continue_threshold;
        logic [11:0] max_length;
        logic [11:0] min_length;
        logic [10:0] cooldown_length;
        logic [6:0]  pre_margin;
        logic [7:0]  post_margin;
        logic [10:0] lookahead;
    } cfg_t;

    // 0.70 and 0.35 in Q0.16
    localparam logic [15:0] RST_START_THRESHOLD    = 16'd45875;
    localparam logic [15:0] RST_CONTINUE_THRESHOLD = 16'd22938;
    localparam logic [11:0] RST_MAX_LENGTH         = 12'd240;
    localparam logic [11:0] RST_MIN_LENGTH         = 12'd2;
    localparam logic [10:0] RST_COOLDOWN_LENGTH    = 11'd192;
    localparam logic [6:0]  RST_PRE_MARGIN         = 7'd17;
    localparam logic [7:0]  RST_POST_MARGIN        = 8'd34;
    localparam logic [10:0] RST_LOOKAHEAD          = 11'd720;

    // Emission waits this many samples beyond end plus post margin
    localparam idx_t EMIT_DELAY = idx_t'(2);

    typedef struct packed {
        logic fire;
        idx_t region_start;
        idx_t region_end;
        logic in_window;
    } lane_result_t;

endpackage

[design/crd_cfg_regs.sv]
// ---------------------------------------------------------------------------
// crd_cfg_regs
// Configuration register file; one write transaction per cycle, always ready.
// ---------------------------------------------------------------------------
module crd_cfg_regs (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  crd_pkg::cfg_index_t    cfg_index,
    input  logic [crd_pkg::CFG_DATA_BITS-1:0] cfg_data,
    output crd_pkg::cfg_t          cfg
);

    crd_pkg::cfg_t cfg_reg;
    crd_pkg::cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                crd_pkg::CFG_START_THRESHOLD:    cfg_next.start_threshold    = cfg_data;
                crd_pkg::CFG_CONTINUE_THRESHOLD: cfg_next.continue_threshold = cfg_data;
                crd_pkg::CFG_MAX_LENGTH:         cfg_next.max_length         = cfg_data[11:0];
                crd_pkg::CFG_MIN_LENGTH:         cfg_next.min_length         = cfg_data[11:0];
                crd_pkg::CFG_COOLDOWN_LENGTH:    cfg_next.cooldown_length    = cfg_data[10:0];
                crd_pkg::CFG_PRE_MARGIN:         cfg_next.pre_margin         = cfg_data[6:0];
                crd_pkg::CFG_POST_MARGIN:        cfg_next.post_margin        = cfg_data[7:0];
                crd_pkg::CFG_LOOKAHEAD:          cfg_next.lookahead          = cfg_data[10:0];
                default:                         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_threshold    <= crd_pkg::RST_START_THRESHOLD;
            cfg_reg.continue_threshold <= crd_pkg::RST_CONTINUE_THRESHOLD;
            cfg_reg.max_length         <= crd_pkg::RST_MAX_LENGTH;
            cfg_reg.min_length         <= crd_pkg::RST_MIN_LENGTH;
            cfg_reg.cooldown_length    <= crd_pkg::RST_COOLDOWN_LENGTH;
            cfg_reg.pre_margin         <= crd_pkg::RST_PRE_MARGIN;
            cfg_reg.post_margin        <= crd_pkg::RST_POST_MARGIN;
            cfg_reg.lookahead          <= crd_pkg::RST_LOOKAHEAD;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

[design/crd_lane.sv]
// ---------------------------------------------------------------------------
// crd_lane
// Run tracking, cooldown and pending region state; one registered update per step.
// ---------------------------------------------------------------------------
module crd_lane (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step,
    input  logic [15:0]           score,
    input  logic                  enable,
    input  crd_pkg::cfg_t         cfg,
    output crd_pkg::lane_result_t result
);

    localparam int IB = crd_pkg::INDEX_BITS;

    crd_pkg::idx_t sample_index_reg, sample_index_next;
    logic [10:0]   cooldown_reg, cooldown_next;
    logic          run_active_reg, run_active_next;
    crd_pkg::idx_t run_start_reg, run_start_next;
    logic [11:0]   run_length_reg, run_length_next;
    logic          pend_flag_reg, pend_flag_next;
    crd_pkg::idx_t pend_start_reg, pend_start_next;
    crd_pkg::idx_t pend_end_reg, pend_end_next;

    crd_pkg::idx_t cur;
    crd_pkg::idx_t pre_ext;
    crd_pkg::idx_t post_ext;
    crd_pkg::idx_t look_ext;
    crd_pkg::idx_t due_diff;
    crd_pkg::idx_t rs;
    crd_pkg::idx_t re;
    crd_pkg::idx_t win_diff;

    assign cur      = sample_index_reg;
    assign pre_ext  = {{(IB-7){1'b0}}, cfg.pre_margin};
    assign post_ext = {{(IB-8){1'b0}}, cfg.post_margin};
    assign look_ext = {{(IB-11){1'b0}}, cfg.lookahead};

    always_comb
    begin
        sample_index_next = cur + crd_pkg::idx_t'(1);
        cooldown_next     = cooldown_reg;
        run_active_next   = run_active_reg;
        run_start_next    = run_start_reg;
        run_length_next   = run_length_reg;
        pend_flag_next    = pend_flag_reg;
        pend_start_next   = pend_start_reg;
        pend_end_next     = pend_end_reg;
        due_diff          = '0;
        rs                = '0;
        re                = '0;
        win_diff          = '0;
        result            = '0;

        if (!enable)
        begin
            cooldown_next   = '0;
            run_active_next = 1'b0;
            run_start_next  = '0;
            run_length_next = '0;
            pend_flag_next  = 1'b0;
            pend_start_next = '0;
            pend_end_next   = '0;
        end
        else
        begin
            if (cooldown_reg != 11'd0)
            begin
                cooldown_next = cooldown_reg - 11'd1;
            end
            else if (!run_active_reg)
            begin
                if (score > cfg.start_threshold)
                begin
                    run_active_next = 1'b1;
                    run_start_next  = cur;
                    run_length_next = 12'd1;
                end
            end
            else if (score > cfg.continue_threshold)
            begin
                // length checked before counting, so it never overflows
                if (run_length_reg >= cfg.max_length)
                begin
                    run_active_next = 1'b0;
                    run_start_next  = '0;
                    run_length_next = '0;
                    cooldown_next   = cfg.cooldown_length;
                end
                else
                begin
                    run_length_next = run_length_reg + 12'd1;
                end
            end
            else
            begin
                if (run_length_reg >= cfg.min_length && run_length_reg <= cfg.max_length
                    && !pend_flag_reg)
                begin
                    pend_flag_next  = 1'b1;
                    pend_start_next = run_start_reg;
                    pend_end_next   = cur - crd_pkg::idx_t'(1);
                    cooldown_next   = cfg.cooldown_length;
                end
                run_active_next = 1'b0;
                run_start_next  = '0;
                run_length_next = '0;
            end

            // wrapped difference read as signed: due once non-negative
            due_diff = cur - (pend_end_next + post_ext + crd_pkg::EMIT_DELAY);
            rs       = pend_start_next - pre_ext;
            re       = pend_end_next + post_ext;
            win_diff = rs - (cur - look_ext);
            if (pend_flag_next && !due_diff[IB-1])
            begin
                result.fire         = 1'b1;
                result.region_start = rs;
                result.region_end   = re;
                result.in_window    = (win_diff != '0) && !win_diff[IB-1];
                pend_flag_next      = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_index_reg <= '0;
            cooldown_reg     <= '0;
            run_active_reg   <= 1'b0;
            run_start_reg    <= '0;
            run_length_reg   <= '0;
            pend_flag_reg    <= 1'b0;
            pend_start_reg   <= '0;
            pend_end_reg     <= '0;
        end
        else if (step)
        begin
            sample_index_reg <= sample_index_next;
            cooldown_reg     <= cooldown_next;
            run_active_reg   <= run_active_next;
            run_start_reg    <= run_start_next;
            run_length_reg   <= run_length_next;
            pend_flag_reg    <= pend_flag_next;
            pend_start_reg   <= pend_start_next;
            pend_end_reg     <= pend_end_next;
        end
    end

endmodule

[design/click_region_detector.sv]
// Path: accepted samples wait in the input register, results in the result register.
// Throughput: one sample per cycle, set by the lane update between the input register and
// the result register; a stalled result holds the input register.
// Reset: asynchronous, active low; configuration returns to its defaults and all lane
// state clears at once, with no clearing pass.
// ---------------------------------------------------------------------------
// click_region_detector
// Hysteresis click run detector with hold-off, emitting margin-widened regions.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module click_region_detector (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  crd_pkg::cfg_index_t    cfg_index,
    input  logic [crd_pkg::CFG_DATA_BITS-1:0] cfg_data,
    input  logic                   sample_valid,
    output logic                   sample_ready,
    input  logic [15:0]            score,
    input  logic                   enable,
    output logic                   region_valid,
    input  logic                   region_ready,
    output crd_pkg::idx_t          region_start,
    output crd_pkg::idx_t          region_end,
    output logic                   in_window
);

    crd_pkg::cfg_t         cfg;
    crd_pkg::lane_result_t lane_res;

    logic          s1_valid_reg, s1_valid_next;
    logic [15:0]   s1_score_reg;
    logic          s1_enable_reg;
    logic          s1_advance;
    logic          accept;
    logic          out_free;

    logic          out_valid_reg, out_valid_next;
    crd_pkg::idx_t out_start_reg;
    crd_pkg::idx_t out_end_reg;
    logic          out_win_reg;

    crd_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    crd_lane u_lane (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (s1_advance),
        .score  (s1_score_reg),
        .enable (s1_enable_reg),
        .cfg    (cfg),
        .result (lane_res)
    );

    assign out_free     = !out_valid_reg || region_ready;
    assign s1_advance   = s1_valid_reg && out_free;
    assign sample_ready = !s1_valid_reg || s1_advance;
    assign accept       = sample_valid && sample_ready;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
            s1_valid_next = 1'b1;
        else if (s1_advance)
            s1_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (s1_advance && lane_res.fire)
            out_valid_next = 1'b1;
        else if (region_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_score_reg  <= score;
            s1_enable_reg <= enable;
        end
        if (s1_advance && lane_res.fire)
        begin
            out_start_reg <= lane_res.region_start;
            out_end_reg   <= lane_res.region_end;
            out_win_reg   <= lane_res.in_window;
        end
    end

    assign region_valid = out_valid_reg;
    assign region_start = out_start_reg;
    assign region_end   = out_end_reg;
    assign in_window    = out_win_reg;

    // a held sample is never dropped while the result side stalls
    `CRD_ASSERT_NEXT(a_s1_hold, s1_valid_reg && !s1_advance, s1_valid_reg, "sample lost in input register")
    // an empty result register never blocks input
    `CRD_ASSERT_IMPLIES(a_no_false_stall, !out_valid_reg, sample_ready, "input stalled with free output")
    // a disabled sample never emits a region
    `CRD_ASSERT_IMPLIES(a_disabled_quiet, s1_valid_reg && !s1_enable_reg, !lane_res.fire, "region emitted while disabled")
    // a stalled result is not overwritten
    `CRD_ASSERT_NEXT(a_out_hold, out_valid_reg && !region_ready, out_valid_reg && $stable(out_start_reg), "stalled result overwritten")

endmodule

[test/click_region_detector_checker.sv]
// ---------------------------------------------------------------------------
// click_region_detector_checker
// Watches the register, sample and region channels of the click region
// detector, predicts each region from its own copy of the lane state and
// compares every region transaction with the oldest prediction.
// ---------------------------------------------------------------------------
module click_region_detector_checker (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  crd_pkg::cfg_index_t  cfg_index,
    input  logic [15:0]          cfg_data,
    input  logic                 sample_valid,
    input  logic                 sample_ready,
    input  logic [15:0]          score,
    input  logic                 enable,
    input  logic                 region_valid,
    input  logic                 region_ready,
    input  crd_pkg::idx_t        region_start,
    input  crd_pkg::idx_t        region_end,
    input  logic                 in_window,
    input  logic                 run_done,
    output int                   fail_count,
    output int                   regions_pending,
    output int                   regions_checked
);
    import crd_pkg::*;

    typedef struct {
        idx_t start_idx;
        idx_t end_idx;
        logic in_win;
    } region_t;

    cfg_t        cfg;
    idx_t        next_index;
    logic [10:0] hold_cnt;
    logic        run_open;
    idx_t        run_first;
    logic [11:0] run_len;
    logic        pend;
    idx_t        pend_first;
    idx_t        pend_last;
    region_t     region_q[$];
    bit          leftovers_done;

    task automatic clear_run();
        run_open  = 1'b0;
        run_first = '0;
        run_len   = '0;
    endtask

    // One sample of the lane; queues the region it releases, if any
    task automatic advance_lane(input logic [15:0] sc, input logic en);
        idx_t    cur;
        idx_t    due_at;
        idx_t    oldest;
        idx_t    diff;
        region_t r;
        cur = next_index;
        if (!en) begin
            clear_run();
            hold_cnt   = '0;
            pend       = 1'b0;
            pend_first = '0;
            pend_last  = '0;
        end
        else begin
            if (hold_cnt != '0)
                hold_cnt = hold_cnt - 1'b1;
            else if (!run_open) begin
                if (sc > cfg.start_threshold)
                begin
                    run_open  = 1'b1;
                    run_first = cur;
                    run_len   = 12'd1;
                end
            end
            else if (sc > cfg.continue_threshold) begin
                // length is compared before it is counted
                if (run_len >= cfg.max_length)
                begin
                    clear_run();
                    hold_cnt = cfg.cooldown_length;
                end
                else
                    run_len = run_len + 1'b1;
            end
            else begin
                if (run_len >= cfg.min_length && run_len <= cfg.max_length && !pend)
                begin
                    pend       = 1'b1;
                    pend_first = run_first;
                    pend_last  = cur - 1'b1;
                    hold_cnt   = cfg.cooldown_length;
                end
                clear_run();
            end
            if (pend) begin
                due_at = pend_last + idx_t'(cfg.post_margin) + EMIT_DELAY;
                diff   = cur - due_at;
                if (!diff[INDEX_BITS-1])
                begin
                    r.start_idx = pend_first - idx_t'(cfg.pre_margin);
                    r.end_idx   = pend_last + idx_t'(cfg.post_margin);
                    oldest      = cur - idx_t'(cfg.lookahead);
                    diff        = r.start_idx - oldest;
                    r.in_win    = (diff != '0) && !diff[INDEX_BITS-1];
                    region_q.push_back(r);
                    pend = 1'b0;
                end
            end
        end
        next_index = cur + 1'b1;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        region_t exp;
        if (!rst_n) begin
            cfg.start_threshold    = RST_START_THRESHOLD;
            cfg.continue_threshold = RST_CONTINUE_THRESHOLD;
            cfg.max_length         = RST_MAX_LENGTH;
            cfg.min_length         = RST_MIN_LENGTH;
            cfg.cooldown_length    = RST_COOLDOWN_LENGTH;
            cfg.pre_margin         = RST_PRE_MARGIN;
            cfg.post_margin        = RST_POST_MARGIN;
            cfg.lookahead          = RST_LOOKAHEAD;
            next_index      = '0;
            hold_cnt        = '0;
            clear_run();
            pend            = 1'b0;
            pend_first      = '0;
            pend_last       = '0;
            region_q.delete();
            leftovers_done  = 1'b0;
            fail_count      = 0;
            regions_checked = 0;
            regions_pending = 0;
        end
        else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_START_THRESHOLD:    cfg.start_threshold    = cfg_data;
                    CFG_CONTINUE_THRESHOLD: cfg.continue_threshold = cfg_data;
                    CFG_MAX_LENGTH:         cfg.max_length         = cfg_data[11:0];
                    CFG_MIN_LENGTH:         cfg.min_length         = cfg_data[11:0];
                    CFG_COOLDOWN_LENGTH:    cfg.cooldown_length    = cfg_data[10:0];
                    CFG_PRE_MARGIN:         cfg.pre_margin         = cfg_data[6:0];
                    CFG_POST_MARGIN:        cfg.post_margin        = cfg_data[7:0];
                    CFG_LOOKAHEAD:          cfg.lookahead          = cfg_data[10:0];
                    default: ;
                endcase
            end

            if (region_valid && region_ready) begin
                if (region_q.size() == 0) begin
                    $display("%0t unexpected region transaction: start %h end %h in_window %b",
                             $time, region_start, region_end, in_window);
                    fail_count++;
                end
                else begin
                    exp = region_q.pop_front();
                    regions_checked++;
                    if (region_start !== exp.start_idx) begin
                        $display("%0t region_start mismatch: expected %h actual %h",
                                 $time, exp.start_idx, region_start);
                        fail_count++;
                    end
                    if (region_end !== exp.end_idx) begin
                        $display("%0t region_end mismatch: expected %h actual %h",
                                 $time, exp.end_idx, region_end);
                        fail_count++;
                    end
                    if (in_window !== exp.in_win) begin
                        $display("%0t in_window mismatch: expected %b actual %b",
                                 $time, exp.in_win, in_window);
                        fail_count++;
                    end
                end
            end

            if (sample_valid && sample_ready)
                advance_lane(score, enable);

            if (run_done && !leftovers_done) begin
                leftovers_done = 1'b1;
                if (region_q.size() != 0) begin
                    $display("%0t %0d predicted regions never arrived, oldest: start %h end %h",
                             $time, region_q.size(), region_q[0].start_idx,
                             region_q[0].end_idx);
                    fail_count += region_q.size();
                end
            end

            regions_pending = region_q.size();
        end
    end

endmodule

[test/click_region_detector_tb.sv]
// ---------------------------------------------------------------------------
// click_region_detector_tb
// Directed click runs covering latching, overflow, busy pending region, zero
// maximum length and lane disable, then random register settings with mostly
// well-formed click bursts and some noise, with random stalls on both sides in phases 0-3.
// ---------------------------------------------------------------------------
module click_region_detector_tb;
    import crd_pkg::*;

    localparam int CLK_PERIOD      = 12;
    localparam int SETTLE_CYCLES   = 8;
    localparam int PHASE_ITEMS     = 150;
    localparam int RANDOM_PHASES   = 6;
    localparam int REGION_TARGET   = 48;
    localparam int EXTRA_ITEM_CAP  = 3000;
    localparam int WATCHDOG_CYCLES = 400000;
    localparam cfg_index_t CFG_UNUSED = 4'd12;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    cfg_index_t  cfg_index;
    logic [15:0] cfg_data;
    logic        sample_valid;
    logic        sample_ready;
    logic [15:0] score;
    logic        enable;
    logic        region_valid;
    logic        region_ready;
    idx_t        region_start;
    idx_t        region_end;
    logic        in_window;

    logic        run_done;
    int          fail_count;
    int          regions_pending;
    int          regions_checked;

    int          tx_idle_pct;
    int          rx_idle_pct;
    int          samples_sent;
    int          writes_done;
    int          settings_used;

    // thresholds and lengths in force, used to shape click bursts
    logic [15:0] cur_start;
    logic [15:0] cur_cont;
    int          cur_max;
    int          cur_cool;

    click_region_detector u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .score        (score),
        .enable       (enable),
        .region_valid (region_valid),
        .region_ready (region_ready),
        .region_start (region_start),
        .region_end   (region_end),
        .in_window    (in_window)
    );

    click_region_detector_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .sample_valid    (sample_valid),
        .sample_ready    (sample_ready),
        .score           (score),
        .enable          (enable),
        .region_valid    (region_valid),
        .region_ready    (region_ready),
        .region_start    (region_start),
        .region_end      (region_end),
        .in_window       (in_window),
        .run_done        (run_done),
        .fail_count      (fail_count),
        .regions_pending (regions_pending),
        .regions_checked (regions_checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    initial
    begin
        #(CLK_PERIOD * WATCHDOG_CYCLES);
        $display("click_region_detector_tb NOT OK");
        $finish;
    end

    always @(negedge clk)
        region_ready <= ($urandom_range(0, 99) >= rx_idle_pct);

    // Holds valid until the transaction; leaves it high for a following one
    task automatic send_sample(input logic [15:0] sc, input logic en);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            sample_valid <= 1'b0;
            @(negedge clk);
        end
        sample_valid <= 1'b1;
        score        <= sc;
        enable       <= en;
        @(posedge clk);
        while (!sample_ready) @(posedge clk);
        @(negedge clk);
        samples_sent++;
    endtask

    // Sender holds off until every predicted region is out and the pipe is empty
    task automatic drain_regions();
        sample_valid <= 1'b0;
        @(negedge clk);
        while (regions_pending != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [15:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        writes_done++;
    endtask

    // junk sets random bits above each field's width, which must be ignored
    task automatic write_settings(input logic [15:0] st, input logic [15:0] ct,
                                  input int maxl, input int minl, input int cool,
                                  input int pre, input int post, input int look,
                                  input bit junk);
        logic [15:0] hi;
        hi = junk ? 16'($urandom) : 16'h0000;
        write_reg(CFG_START_THRESHOLD, st);
        write_reg(CFG_CONTINUE_THRESHOLD, ct);
        write_reg(CFG_MAX_LENGTH, {hi[15:12], 12'(maxl)});
        write_reg(CFG_MIN_LENGTH, {hi[15:12], 12'(minl)});
        write_reg(CFG_COOLDOWN_LENGTH, {hi[15:11], 11'(cool)});
        write_reg(CFG_PRE_MARGIN, {hi[15:7], 7'(pre)});
        write_reg(CFG_POST_MARGIN, {hi[15:8], 8'(post)});
        write_reg(CFG_LOOKAHEAD, {hi[15:11], 11'(look)});
        if (junk)
            write_reg(CFG_UNUSED, 16'($urandom));
        cfg_valid <= 1'b0;
        @(negedge clk);
        cur_start = st;
        cur_cont  = ct;
        cur_max   = maxl;
        cur_cool  = cool;
        settings_used++;
    endtask

    function automatic logic [15:0] quiet_score();
        return 16'($urandom_range(0, int'(cur_cont)));
    endfunction

    function automatic logic [15:0] above(input logic [15:0] thr);
        if (thr == 16'hFFFF)
            return 16'hFFFF;
        return 16'($urandom_range(int'(thr) + 1, 65535));
    endfunction

    // Quiet lead-in, one opening sample, a continuing run, a closing sample, a quiet tail
    task automatic send_click();
        int lead;
        int len;
        int tail;
        int k;
        lead = $urandom_range(0, 4);
        len  = $urandom_range(1, (cur_max + 2 < 40) ? cur_max + 2 : 40);
        tail = $urandom_range(0, (cur_cool < 24) ? cur_cool : 24);
        for (k = 0; k < lead; k++)
            send_sample(quiet_score(), 1'b1);
        send_sample(above(cur_start), 1'b1);
        for (k = 1; k < len; k++)
            send_sample(above(cur_cont), ($urandom_range(0, 99) != 0));
        send_sample(quiet_score(), 1'b1);
        for (k = 0; k < tail; k++)
            send_sample(quiet_score(), 1'b1);
    endtask

    task automatic send_noise();
        int n;
        int k;
        n = $urandom_range(1, 8);
        for (k = 0; k < n; k++)
            send_sample(16'($urandom), ($urandom_range(0, 15) != 0));
    endtask

    initial
    begin
        int ph;
        int target;
        int pick;
        int maxl;
        int post_top;
        logic [15:0] st;

        rst_n         = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = CFG_START_THRESHOLD;
        cfg_data      = 16'h0000;
        sample_valid  = 1'b0;
        score         = 16'h0000;
        enable        = 1'b0;
        region_ready  = 1'b0;
        run_done      = 1'b0;
        tx_idle_pct   = 0;
        rx_idle_pct   = 0;
        samples_sent  = 0;
        writes_done   = 0;
        settings_used = 0;
        cur_start     = RST_START_THRESHOLD;
        cur_cont      = RST_CONTINUE_THRESHOLD;
        cur_max       = RST_MAX_LENGTH;
        cur_cool      = RST_COOLDOWN_LENGTH;

        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: short runs, no cooldown, small window
        write_settings(16'h8000, 16'h4000, 3, 2, 0, 5, 6, 20, 1'b0);
        send_sample(16'h0000, 1'b1);
        send_sample(16'hFFFF, 1'b1);
        send_sample(16'hFFFF, 1'b1);
        send_sample(16'h0000, 1'b1);    // latches; start minus margin wraps
        send_sample(16'hFFFF, 1'b1);
        send_sample(16'hFFFF, 1'b1);
        send_sample(16'h4000, 1'b1);    // valid run ends while region pending
        send_sample(16'h8000, 1'b1);    // equal to threshold, does not open
        send_sample(16'h8001, 1'b1);
        send_sample(16'hFFFF, 1'b1);
        send_sample(16'hFFFF, 1'b1);    // pending region due here
        send_sample(16'hFFFF, 1'b1);    // run at max length continues: dropped
        send_sample(16'hFFFF, 1'b0);
        send_sample(16'hFFFF, 1'b1);
        send_sample(16'h7FFF, 1'b0);    // disable mid-run
        send_sample(16'hFFFF, 1'b1);
        send_sample(16'hFFFF, 1'b1);
        send_sample(16'h0000, 1'b1);
        send_sample(16'h1234, 1'b0);    // disable drops the pending region
        drain_regions();

        // directed: zero max length never latches
        write_settings(16'h8000, 16'h4000, 0, 1, 2, 0, 0, 0, 1'b0);
        send_sample(16'hFFFF, 1'b1);
        send_sample(16'hFFFF, 1'b1);
        send_sample(16'hFFFF, 1'b1);
        send_sample(16'hFFFF, 1'b1);
        send_sample(16'hFFFF, 1'b1);
        send_sample(16'h0000, 1'b1);

        for (ph = 0; ph < RANDOM_PHASES; ph++) begin
            drain_regions();
            case (ph / 2)
                0: begin tx_idle_pct = 32; rx_idle_pct = 46; end
                1: begin tx_idle_pct = 46; rx_idle_pct = 32; end
                default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
            endcase
            case (ph)
                0: write_settings(RST_START_THRESHOLD, RST_CONTINUE_THRESHOLD,
                                  RST_MAX_LENGTH, RST_MIN_LENGTH, RST_COOLDOWN_LENGTH,
                                  RST_PRE_MARGIN, RST_POST_MARGIN, RST_LOOKAHEAD, 1'b0);
                1: write_settings(16'h0000, 16'h0000, 2048, 1, 0, 96, 128, 1024, 1'b1);
                2: write_settings(16'hFFFE, 16'hFFFF, 1, 1, 1024, 0, 0, 0, 1'b1);
                default: begin
                    st       = 16'($urandom_range(16'h6000, 16'hF000));
                    maxl     = $urandom_range(1, 24);
                    post_top = (ph == 4) ? 128 : 40;
                    write_settings(st, 16'($urandom_range(16'h1000, int'(st))), maxl,
                                   $urandom_range(1, maxl + 2), $urandom_range(0, 16),
                                   $urandom_range(0, 96), $urandom_range(0, post_top),
                                   $urandom_range(0, 1024), 1'b1);
                end
            endcase
            target = samples_sent + PHASE_ITEMS;
            // last phase runs on until enough regions have been seen or the extra sample cap is reached
            while (samples_sent < target ||
                   (ph == RANDOM_PHASES - 1 &&
                    regions_checked + regions_pending < REGION_TARGET &&
                    samples_sent < target + EXTRA_ITEM_CAP)) begin
                pick = $urandom_range(0, 99);
                if (pick < 2)
                    drain_regions();
                else if (pick < 80)
                    send_click();
                else
                    send_noise();
            end
        end

        drain_regions();
        rx_idle_pct = 0;
        run_done    = 1'b1;
        @(negedge clk);
        @(negedge clk);

        $display("Run covered %0d sample transactions under %0d register settings (%0d writes)",
                 samples_sent, settings_used, writes_done);
        $display("%0d regions compared with prediction, %0d failures",
                 regions_checked, fail_count);
        if (fail_count == 0)
            $display("click_region_detector_tb OK");
        else
            $display("click_region_detector_tb NOT OK");
        $finish;
    end

endmodule
